@@ sv/gft_pkg.sv @@
`default_nettype none
package gft_pkg;

    localparam int POSITION_WIDTH_DEF = 24;
    localparam int NEST_DEPTH_MAX_DEF = 255;
    localparam int QUEUE_DEPTH        = 4;
    localparam int KIND_W             = 5;

    // token kinds
    localparam logic [KIND_W-1:0] TK_EOF       = 5'd0;
    localparam logic [KIND_W-1:0] TK_ERROR     = 5'd1;
    localparam logic [KIND_W-1:0] TK_TEXT      = 5'd2;
    localparam logic [KIND_W-1:0] TK_EXTERN    = 5'd3;
    localparam logic [KIND_W-1:0] TK_SLASH     = 5'd6;
    localparam logic [KIND_W-1:0] TK_CHARLIT   = 5'd7;
    localparam logic [KIND_W-1:0] TK_CODE      = 5'd8;
    localparam logic [KIND_W-1:0] TK_EXTRA     = 5'd9;
    localparam logic [KIND_W-1:0] TK_LPAREN    = 5'd10;
    localparam logic [KIND_W-1:0] TK_POUND     = 5'd11;
    localparam logic [KIND_W-1:0] TK_RPAREN    = 5'd12;
    localparam logic [KIND_W-1:0] TK_STAR      = 5'd13;
    localparam logic [KIND_W-1:0] TK_PLUS      = 5'd14;
    localparam logic [KIND_W-1:0] TK_COMMA     = 5'd15;
    localparam logic [KIND_W-1:0] TK_COLON     = 5'd16;
    localparam logic [KIND_W-1:0] TK_SEMICOLON = 5'd17;
    localparam logic [KIND_W-1:0] TK_QUESTION  = 5'd18;
    localparam logic [KIND_W-1:0] TK_BAR       = 5'd19;
    localparam logic [KIND_W-1:0] TK_IDENT     = 5'd20;
    localparam logic [KIND_W-1:0] TK_LAST      = 5'd20;

    // input item kinds
    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_END  = 1'b1;

    // block kinds held in the progress register while a block is open
    localparam logic [5:0] BK_TEXT  = 6'd0;
    localparam logic [5:0] BK_CODE  = 6'd1;
    localparam logic [5:0] BK_EXTRA = 6'd2;

    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_PERCENT = "%";
    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_STAR    = "*";
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_LBRACE  = "{";
    localparam logic [7:0] CH_RBRACE  = "}";
    localparam logic [7:0] CH_LPAREN  = "(";
    localparam logic [7:0] CH_RPAREN  = ")";
    localparam logic [7:0] CH_POUND   = "#";
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_COMMA   = ",";
    localparam logic [7:0] CH_COLON   = ":";
    localparam logic [7:0] CH_SEMI    = ";";
    localparam logic [7:0] CH_QUEST   = "?";
    localparam logic [7:0] CH_BAR     = "|";
    localparam logic [7:0] CH_UNDER   = "_";

    typedef enum logic [16:0] {
        MODE_IDLE          = 17'd1 << 0,
        MODE_PCT           = 17'd1 << 1,
        MODE_DIRECTIVE     = 17'd1 << 2,
        MODE_SLASH         = 17'd1 << 3,
        MODE_LINECMT       = 17'd1 << 4,
        MODE_CMT           = 17'd1 << 5,
        MODE_CMT_STAR      = 17'd1 << 6,
        MODE_CHARLIT       = 17'd1 << 7,
        MODE_CHARLIT_ESC   = 17'd1 << 8,
        MODE_IDENT         = 17'd1 << 9,
        MODE_BLK           = 17'd1 << 10,
        MODE_BLK_SLASH     = 17'd1 << 11,
        MODE_BLK_LINECMT   = 17'd1 << 12,
        MODE_BLK_CMT       = 17'd1 << 13,
        MODE_BLK_CMT_STAR  = 17'd1 << 14,
        MODE_BLK_QUOTE     = 17'd1 << 15,
        MODE_BLK_QUOTE_ESC = 17'd1 << 16
    } scan_mode_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9") || (c == CH_UNDER);
    endfunction

    function automatic logic [2:0] dir_len(input logic [1:0] w);
        return (w == 2'd0) ? 3'd6 : 3'd5;
    endfunction

    function automatic logic [7:0] dir_char(input logic [1:0] w, input logic [2:0] k);
        logic [47:0] s;
        logic [7:0]  r;
        case (w)
            2'd0:    s = "extern";
            2'd1:    s = {"token", 8'h00};
            default: s = {"class", 8'h00};
        endcase
        case (k)
            3'd0:    r = s[47:40];
            3'd1:    r = s[39:32];
            3'd2:    r = s[31:24];
            3'd3:    r = s[23:16];
            3'd4:    r = s[15:8];
            3'd5:    r = s[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // candidate mask in bits 2:0, matched count in bits 5:3
    function automatic logic [5:0] dir_feed(input logic [5:0] p, input logic [7:0] c);
        logic [2:0] mask;
        logic [2:0] cnt;
        mask = p[2:0];
        cnt  = p[5:3];
        for (int i = 0; i < 3; i++) begin
            if (cnt >= dir_len(2'(i)) || dir_char(2'(i), cnt) != c) begin
                mask[i] = 1'b0;
            end
        end
        if (cnt != 3'd7) begin
            cnt = cnt + 3'd1;
        end
        return {cnt, mask};
    endfunction

    function automatic logic [KIND_W-1:0] dir_kind(input logic [5:0] p);
        logic [KIND_W-1:0] k;
        k = TK_ERROR;
        for (int i = 2; i >= 0; i--) begin
            if (p[i] && p[5:3] == dir_len(2'(i))) begin
                k = TK_EXTERN + KIND_W'(i);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

@@ sv/grammar_file_tokenizer.sv @@
// grammar file tokenizer: source bytes go in one per transfer on the s_ channel and
// grammar tokens come out on the m_ channel, each with its kind, the start offset
// and length of its carried text, the line on which it began, and a flag on the
// last token that a byte caused. a byte may cause none, one or two tokens; an end
// item (or a zero byte) flushes any pending token, emits end-of-file and returns
// the scanner to its reset state for a new stream. one byte is taken every cycle
// while the output side keeps up: the scanner works each byte combinationally and
// its tokens enter the token queue at the input transfer. a four-entry token queue
// sits between scanner and output; s_ready is low while fewer than two entries are
// free, so a stalled consumer holds off the input after three or four tokens.
// offsets and line numbers saturate at all ones; no clearing pass after reset
`default_nettype none
module grammar_file_tokenizer
    import gft_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int NEST_DEPTH_MAX = NEST_DEPTH_MAX_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_kind,
    input  wire logic [7:0]                s_source_byte,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic      [KIND_W-1:0]         m_token_kind,
    output logic      [POSITION_WIDTH-1:0] m_text_start,
    output logic      [POSITION_WIDTH-1:0] m_text_length,
    output logic      [POSITION_WIDTH-1:0] m_token_line,
    output logic                           m_last_of_run
);

    localparam int PW = POSITION_WIDTH;
    // token word: kind, start, length, line, last flag
    localparam int TW = KIND_W + 3 * PW + 1;

    logic [TW-1:0] tok0, tok1, head;
    logic [1:0]    push;
    logic          in_fire;

    // input transfer
    assign in_fire = s_valid && s_ready;

    // front: classifies each byte and builds tokens
    gft_scanner #(
        .PW       (PW),
        .NEST_MAX (NEST_DEPTH_MAX),
        .TW       (TW)
    ) u_scanner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_kind (s_kind),
        .in_byte (s_source_byte),
        .tok0    (tok0),
        .tok1    (tok1),
        .push    (push)
    );

    // back: token queue that drives the output channel
    gft_token_queue #(
        .TW (TW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok0      (tok0),
        .tok1      (tok1),
        .push      (push),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (head)
    );

    // unpack the head token
    assign m_token_kind  = head[TW-1 -: KIND_W];
    assign m_text_start  = head[3*PW -: PW];
    assign m_text_length = head[2*PW -: PW];
    assign m_token_line  = head[PW -: PW];
    assign m_last_of_run = head[0];

endmodule
`default_nettype wire

@@ sv/gft_scanner.sv @@
`default_nettype none
module gft_scanner
    import gft_pkg::*;
#(
    parameter int PW       = POSITION_WIDTH_DEF,
    parameter int NEST_MAX = NEST_DEPTH_MAX_DEF,
    parameter int TW       = KIND_W + 3 * PW + 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic          in_kind,
    input  wire logic [7:0]    in_byte,
    output logic      [TW-1:0] tok0,
    output logic      [TW-1:0] tok1,
    output logic      [1:0]    push
);

    localparam int NW = $clog2(NEST_MAX + 1);
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    scan_mode_t    mode_reg, mode_next;
    logic [NW-1:0] nest_reg, nest_next;
    logic [7:0]    quote_reg, quote_next;
    logic [7:0]    prior_reg, prior_next;
    logic [5:0]    prog_reg, prog_next;
    logic [PW-1:0] off_reg, off_next;
    logic [PW-1:0] line_reg, line_next;
    logic [PW-1:0] soff_reg, soff_next;
    logic [PW-1:0] sline_reg, sline_next;

    function automatic logic [PW-1:0] add_sat(input logic [PW-1:0] a, input logic [1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {{(PW - 1){1'b0}}, b};
        return s[PW] ? POS_MAX : s[PW-1:0];
    endfunction

    function automatic logic [TW-1:0] mk_tok(input logic [KIND_W-1:0] k,
        input logic [PW-1:0] st, input logic [PW-1:0] len, input logic [PW-1:0] ln);
        return {k, st, len, ln, 1'b0};
    endfunction

    function automatic logic [TW-1:0] fin_tok(input logic [PW-1:0] end_off,
        input logic [5:0] bk, input logic [PW-1:0] so, input logic [PW-1:0] sl);
        logic [PW-1:0] total;
        total = end_off - so;
        if (bk == BK_TEXT) begin
            return mk_tok(TK_TEXT, add_sat(so, 2'd2),
                (total >= PW'(4)) ? total - PW'(4) : '0, sl);
        end else if (bk == BK_EXTRA) begin
            return mk_tok(TK_EXTRA, add_sat(so, 2'd1),
                (total >= PW'(2)) ? total - PW'(2) : '0, sl);
        end
        return mk_tok(TK_CODE, so, total, sl);
    endfunction

    logic [7:0]        c;
    logic              is_end;
    logic [PW-1:0]     off_inc;
    logic [KIND_W-1:0] pend_kind;

    // idle classification of the current byte
    scan_mode_t        idle_mode;
    logic              idle_emit, idle_open;
    logic [KIND_W-1:0] idle_kind;
    logic [5:0]        idle_bk;

    // block body handling of the current byte
    scan_mode_t        body_mode;
    logic [NW-1:0]     body_nest;
    logic              body_fin, body_quote;

    logic              do_pend, do_idle, do_body;
    logic              v0, v1;

    assign c       = in_byte;
    assign is_end  = (in_kind == IN_END) || (c == 8'h00);
    assign off_inc = add_sat(off_reg, 2'd1);

    always_comb begin
        idle_mode = MODE_IDLE;
        idle_emit = 1'b0;
        idle_open = 1'b0;
        idle_kind = TK_ERROR;
        idle_bk   = BK_CODE;
        case (c)
            CH_PERCENT: idle_mode = MODE_PCT;
            CH_SLASH:   idle_mode = MODE_SLASH;
            CH_SQUOTE:  idle_mode = MODE_CHARLIT;
            CH_LBRACE: begin
                idle_mode = MODE_BLK;
                idle_open = 1'b1;
            end
            CH_LPAREN: begin
                if (is_word(prior_reg)) begin
                    idle_mode = MODE_BLK;
                    idle_open = 1'b1;
                    idle_bk   = BK_EXTRA;
                end else begin
                    idle_emit = 1'b1;
                    idle_kind = TK_LPAREN;
                end
            end
            CH_POUND:  begin idle_emit = 1'b1; idle_kind = TK_POUND;     end
            CH_RPAREN: begin idle_emit = 1'b1; idle_kind = TK_RPAREN;    end
            CH_STAR:   begin idle_emit = 1'b1; idle_kind = TK_STAR;      end
            CH_PLUS:   begin idle_emit = 1'b1; idle_kind = TK_PLUS;      end
            CH_COMMA:  begin idle_emit = 1'b1; idle_kind = TK_COMMA;     end
            CH_COLON:  begin idle_emit = 1'b1; idle_kind = TK_COLON;     end
            CH_SEMI:   begin idle_emit = 1'b1; idle_kind = TK_SEMICOLON; end
            CH_QUEST:  begin idle_emit = 1'b1; idle_kind = TK_QUESTION;  end
            CH_BAR:    begin idle_emit = 1'b1; idle_kind = TK_BAR;       end
            default: begin
                if (is_alpha(c) || c == CH_UNDER) begin
                    idle_mode = MODE_IDENT;
                end else if (!is_space(c)) begin
                    idle_emit = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        logic [7:0] left;
        logic [7:0] right;
        left       = (prog_reg == BK_EXTRA) ? CH_LPAREN : CH_LBRACE;
        right      = (prog_reg == BK_EXTRA) ? CH_RPAREN : CH_RBRACE;
        body_mode  = MODE_BLK;
        body_nest  = nest_reg;
        body_fin   = 1'b0;
        body_quote = 1'b0;
        if (c == CH_SLASH) begin
            body_mode = MODE_BLK_SLASH;
        end else if (c == left) begin
            if (32'(nest_reg) < NEST_MAX) begin
                body_nest = nest_reg + NW'(1);
            end
        end else if (c == right) begin
            if (nest_reg != '0) begin
                body_nest = nest_reg - NW'(1);
            end
            if (body_nest == '0) begin
                body_fin  = 1'b1;
                body_mode = MODE_IDLE;
            end
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            body_quote = 1'b1;
            body_mode  = MODE_BLK_QUOTE;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        nest_next  = nest_reg;
        quote_next = quote_reg;
        prior_next = prior_reg;
        prog_next  = prog_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        soff_next  = soff_reg;
        sline_next = sline_reg;
        tok0       = '0;
        tok1       = '0;
        v0         = 1'b0;
        v1         = 1'b0;
        do_pend    = 1'b0;
        do_idle    = 1'b0;
        do_body    = 1'b0;
        pend_kind  = TK_ERROR;

        if (is_end) begin
            case (mode_reg)
                MODE_PCT, MODE_CHARLIT, MODE_CHARLIT_ESC: begin
                    do_pend = 1'b1;
                end
                MODE_DIRECTIVE: begin
                    do_pend   = 1'b1;
                    pend_kind = dir_kind(prog_reg);
                end
                MODE_SLASH: begin
                    do_pend   = 1'b1;
                    pend_kind = TK_SLASH;
                end
                MODE_IDENT: begin
                    do_pend   = 1'b1;
                    pend_kind = TK_IDENT;
                end
                MODE_BLK, MODE_BLK_SLASH, MODE_BLK_LINECMT, MODE_BLK_CMT,
                MODE_BLK_CMT_STAR, MODE_BLK_QUOTE, MODE_BLK_QUOTE_ESC: begin
                    v0   = 1'b1;
                    tok0 = fin_tok(off_reg, prog_reg, soff_reg, sline_reg);
                end
                default: ;
            endcase
            if (do_pend) begin
                v0   = 1'b1;
                tok0 = mk_tok(pend_kind, soff_reg, off_reg - soff_reg, sline_reg);
            end
            if (v0) begin
                v1   = 1'b1;
                tok1 = mk_tok(TK_EOF, off_reg, '0, line_reg);
            end else begin
                v0   = 1'b1;
                tok0 = mk_tok(TK_EOF, off_reg, '0, line_reg);
            end
            mode_next  = MODE_IDLE;
            nest_next  = '0;
            quote_next = '0;
            prior_next = '0;
            prog_next  = '0;
            off_next   = '0;
            line_next  = PW'(1);
            soff_next  = '0;
            sline_next = PW'(1);
        end else begin
            case (mode_reg)
                MODE_PCT: begin
                    if (c == CH_LBRACE) begin
                        mode_next = MODE_BLK;
                        prog_next = BK_TEXT;
                        nest_next = NW'(1);
                    end else if (is_alpha(c)) begin
                        prog_next = dir_feed(6'd7, c);
                        mode_next = MODE_DIRECTIVE;
                    end else begin
                        do_pend = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                MODE_DIRECTIVE: begin
                    if (is_word(c)) begin
                        prog_next = dir_feed(prog_reg, c);
                    end else begin
                        do_pend   = 1'b1;
                        pend_kind = dir_kind(prog_reg);
                        do_idle   = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode_next = MODE_LINECMT;
                    end else if (c == CH_STAR) begin
                        mode_next = MODE_CMT;
                    end else begin
                        do_pend   = 1'b1;
                        pend_kind = TK_SLASH;
                        do_idle   = 1'b1;
                    end
                end
                MODE_LINECMT: begin
                    if (c == CH_NL) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_CMT: begin
                    if (c == CH_STAR) begin
                        mode_next = MODE_CMT_STAR;
                    end
                end
                MODE_CMT_STAR: begin
                    mode_next = (c == CH_SLASH) ? MODE_IDLE :
                                (c == CH_STAR) ? MODE_CMT_STAR : MODE_CMT;
                end
                MODE_CHARLIT: begin
                    if (c == CH_SQUOTE) begin
                        v0        = 1'b1;
                        tok0      = mk_tok(TK_CHARLIT, soff_reg, off_inc - soff_reg,
                                           sline_reg);
                        mode_next = MODE_IDLE;
                    end else if (c == CH_NL) begin
                        do_pend = 1'b1;
                        do_idle = 1'b1;
                    end else if (c == CH_BSLASH) begin
                        mode_next = MODE_CHARLIT_ESC;
                    end
                end
                MODE_CHARLIT_ESC: begin
                    if (c == CH_NL) begin
                        do_pend = 1'b1;
                        do_idle = 1'b1;
                    end else begin
                        mode_next = MODE_CHARLIT;
                    end
                end
                MODE_IDENT: begin
                    if (!is_word(c)) begin
                        do_pend   = 1'b1;
                        pend_kind = TK_IDENT;
                        do_idle   = 1'b1;
                    end
                end
                MODE_BLK: do_body = 1'b1;
                MODE_BLK_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode_next = MODE_BLK_LINECMT;
                    end else if (c == CH_STAR) begin
                        mode_next = MODE_BLK_CMT;
                    end else begin
                        do_body = 1'b1;
                    end
                end
                MODE_BLK_LINECMT: begin
                    if (c == CH_NL) begin
                        do_body = 1'b1;
                    end
                end
                MODE_BLK_CMT: begin
                    if (c == CH_STAR) begin
                        mode_next = MODE_BLK_CMT_STAR;
                    end
                end
                MODE_BLK_CMT_STAR: begin
                    mode_next = (c == CH_SLASH) ? MODE_BLK :
                                (c == CH_STAR) ? MODE_BLK_CMT_STAR : MODE_BLK_CMT;
                end
                MODE_BLK_QUOTE: begin
                    if (c == quote_reg) begin
                        mode_next = MODE_BLK;
                    end else if (c == CH_BSLASH) begin
                        mode_next = MODE_BLK_QUOTE_ESC;
                    end
                end
                MODE_BLK_QUOTE_ESC: mode_next = MODE_BLK_QUOTE;
                default: do_idle = 1'b1;
            endcase

            if (do_pend) begin
                v0   = 1'b1;
                tok0 = mk_tok(pend_kind, soff_reg, off_reg - soff_reg, sline_reg);
            end
            if (do_idle) begin
                mode_next = idle_mode;
                if (!is_space(c)) begin
                    soff_next  = off_reg;
                    sline_next = line_reg;
                end
                if (idle_open) begin
                    prog_next = idle_bk;
                    nest_next = NW'(1);
                end
                if (idle_emit) begin
                    if (v0) begin
                        v1   = 1'b1;
                        tok1 = mk_tok(idle_kind, off_reg, PW'(1), line_reg);
                    end else begin
                        v0   = 1'b1;
                        tok0 = mk_tok(idle_kind, off_reg, PW'(1), line_reg);
                    end
                end
            end
            if (do_body) begin
                mode_next = body_mode;
                nest_next = body_nest;
                if (body_quote) begin
                    quote_next = c;
                end
                if (body_fin) begin
                    v0   = 1'b1;
                    tok0 = fin_tok(off_inc, prog_reg, soff_reg, sline_reg);
                end
            end
            prior_next = c;
            off_next   = off_inc;
            if (c == CH_NL) begin
                line_next = add_sat(line_reg, 2'd1);
            end
        end

        // flag the final result of this byte
        if (v1) begin
            tok1[0] = 1'b1;
        end else if (v0) begin
            tok0[0] = 1'b1;
        end
    end

    assign push = {v1 & in_fire, v0 & in_fire};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            nest_reg  <= '0;
            quote_reg <= '0;
            prior_reg <= '0;
            prog_reg  <= '0;
            off_reg   <= '0;
            line_reg  <= PW'(1);
            soff_reg  <= '0;
            sline_reg <= PW'(1);
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            nest_reg  <= nest_next;
            quote_reg <= quote_next;
            prior_reg <= prior_next;
            prog_reg  <= prog_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            soff_reg  <= soff_next;
            sline_reg <= sline_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/gft_token_queue.sv @@
`default_nettype none
module gft_token_queue
    import gft_pkg::*;
#(
    parameter int TW = KIND_W + 3 * POSITION_WIDTH_DEF + 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [TW-1:0] tok0,
    input  wire logic [TW-1:0] tok1,
    input  wire logic [1:0]    push,
    output logic               room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic      [TW-1:0] out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TW-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          pop;
    logic [CW-1:0] n_push;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = CW'(push[0]) + CW'(push[1]);
    // two free slots cover the worst case of one byte
    assign room      = (32'(cnt_reg) <= QUEUE_DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (push[0]) begin
            mem[wptr_reg] <= tok0;
        end
        if (push[1]) begin
            mem[wptr_reg + AW'(1)] <= tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_reg + AW'(n_push);
            if (pop) begin
                rptr_reg <= rptr_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + n_push - CW'(pop);
        end
    end

endmodule
`default_nettype wire

@@ sv/gft_checker.sv @@
`default_nettype none
module gft_checker
    import gft_pkg::*;
#(
    parameter int PW = POSITION_WIDTH_DEF
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [KIND_W-1:0] m_token_kind,
    input wire logic [PW-1:0]     m_text_start,
    input wire logic [PW-1:0]     m_text_length,
    input wire logic [PW-1:0]     m_token_line,
    input wire logic              m_last_of_run
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("token shown straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind)
            && $stable(m_text_start) && $stable(m_text_length)
            && $stable(m_token_line) && $stable(m_last_of_run))
        else $error("stalled token changed");

    a_eof_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == TK_EOF |-> m_text_length == '0 && m_last_of_run)
        else $error("end-of-file token malformed");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind <= TK_LAST)
        else $error("token kind out of range");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_line != '0)
        else $error("token line is zero");

endmodule

bind grammar_file_tokenizer gft_checker #(.PW(POSITION_WIDTH)) u_gft_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_token_kind  (m_token_kind),
    .m_text_start  (m_text_start),
    .m_text_length (m_text_length),
    .m_token_line  (m_token_line),
    .m_last_of_run (m_last_of_run)
);
`default_nettype wire
